// ----- hdl/b64d_pkg.sv -----
`default_nettype none

package b64d_pkg;

   // field widths
   localparam int CHAR_BITS = 8;
   localparam int SEXTET_BITS = 6;
   localparam int MAX_GROUPS_BITS = 20;
   localparam int MAX_BYTES_BITS = 22;

   // configuration register indexes
   localparam logic CSR_MAX_GROUPS = 1'b0;
   localparam logic CSR_MAX_BYTES = 1'b1;

   // limit register reset values
   localparam logic [MAX_GROUPS_BITS-1:0] MAX_GROUPS_RESET = 20'd1366;
   localparam logic [MAX_BYTES_BITS-1:0] MAX_BYTES_RESET = 22'd4096;

   // status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BADCHAR = 3'd1;
   localparam logic [2:0] ST_PADPOS = 3'd2;
   localparam logic [2:0] ST_PADBITS = 3'd3;
   localparam logic [2:0] ST_TOOLONG = 3'd4;

   localparam logic [CHAR_BITS-1:0] PAD_CHAR = 8'h3D;

   // one decoded group
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] byte_len;
      logic [2:0] status;
   } grp_result_type;

   // alphabet lookup: bit 6 is the valid flag, bits 5:0 the sextet
   function automatic logic [SEXTET_BITS:0] sextet(input logic [CHAR_BITS-1:0] c);
      logic [SEXTET_BITS:0] r;
      r = '0;
      if (c inside {[8'h41:8'h5A]}) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/b64d_group_check.sv -----
`default_nettype none

// Per-group character checks and byte assembly, no message state.
module b64d_group_check
   import b64d_pkg::*;
(
   input  wire logic [CHAR_BITS-1:0] char0,
   input  wire logic [CHAR_BITS-1:0] char1,
   input  wire logic [CHAR_BITS-1:0] char2,
   input  wire logic [CHAR_BITS-1:0] char3,
   input  wire logic                 last_group,
   output grp_result_type            grp
);

   logic [SEXTET_BITS:0] s0, s1, s2, s3;
   logic [SEXTET_BITS-1:0] v2, v3;
   logic ok2, ok3, p2, p3;

   assign s0 = sextet(char0);
   assign s1 = sextet(char1);
   assign s2 = sextet(char2);
   assign s3 = sextet(char3);
   assign p2 = (char2 == PAD_CHAR);
   assign p3 = (char3 == PAD_CHAR);

   // padding stands for a zero sextet
   assign v2 = p2 ? '0 : s2[SEXTET_BITS-1:0];
   assign v3 = p3 ? '0 : s3[SEXTET_BITS-1:0];
   assign ok2 = p2 || s2[SEXTET_BITS];
   assign ok3 = p3 || s3[SEXTET_BITS];

   always_comb begin
      grp = '0;
      // checks in priority order
      if (!s0[SEXTET_BITS] || !s1[SEXTET_BITS]) begin
         grp.status = ST_BADCHAR;
      end else if ((!last_group && (p2 || p3)) || (p2 && !p3)) begin
         grp.status = ST_PADPOS;
      end else if (!ok2 || !ok3) begin
         grp.status = ST_BADCHAR;
      end else if ((p2 && (s1[3:0] != 4'd0)) || (p3 && !p2 && (v2[1:0] != 2'd0))) begin
         grp.status = ST_PADBITS;
      end else begin
         grp.status = ST_OK;
      end

      // bytes for a clean group; gated later on any error
      grp.byte_len = p2 ? 2'd1 : (p3 ? 2'd2 : 2'd3);
      grp.byte0 = {s0[5:0], s1[5:4]};
      if (!p2) begin
         grp.byte1 = {s1[3:0], v2[5:2]};
      end
      if (!p2 && !p3) begin
         grp.byte2 = {v2[1:0], v3};
      end
   end

endmodule

`default_nettype wire

// ----- hdl/b64d_msg_track.sv -----
`default_nettype none

// Message totals, limit registers and the sticky error.
module b64d_msg_track
   import b64d_pkg::*;
#(
   parameter int GROUP_COUNT_BITS = 20,
   parameter int BYTE_COUNT_BITS = 22
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_index,
   input  wire logic [MAX_BYTES_BITS-1:0] csr_data,
   input  wire logic                      step,
   input  wire logic                      last_group,
   input  wire grp_result_type            grp,
   output grp_result_type                 res
);

   localparam int GW = (GROUP_COUNT_BITS > MAX_GROUPS_BITS) ? GROUP_COUNT_BITS
                                                             : MAX_GROUPS_BITS;
   localparam int BW = (BYTE_COUNT_BITS > MAX_BYTES_BITS) ? BYTE_COUNT_BITS
                                                          : MAX_BYTES_BITS;

   logic [MAX_GROUPS_BITS-1:0] max_groups_ff, max_groups_in;
   logic [MAX_BYTES_BITS-1:0]  max_bytes_ff, max_bytes_in;
   logic [GROUP_COUNT_BITS-1:0] group_total_ff, group_total_in;
   logic [BYTE_COUNT_BITS-1:0]  byte_total_ff, byte_total_in;
   logic [2:0] sticky_ff, sticky_in;

   logic [GROUP_COUNT_BITS:0] g_sum;
   logic [BYTE_COUNT_BITS:0]  b_sum;
   logic [GROUP_COUNT_BITS-1:0] g_new;
   logic [BYTE_COUNT_BITS-1:0]  b_new;
   logic over;

   // saturating totals
   assign g_sum = {1'b0, group_total_ff} + (GROUP_COUNT_BITS+1)'(1);
   assign b_sum = {1'b0, byte_total_ff} + (BYTE_COUNT_BITS+1)'(grp.byte_len);
   assign g_new = g_sum[GROUP_COUNT_BITS] ? '1 : g_sum[GROUP_COUNT_BITS-1:0];
   assign b_new = b_sum[BYTE_COUNT_BITS] ? '1 : b_sum[BYTE_COUNT_BITS-1:0];
   assign over = (GW'(g_new) > GW'(max_groups_ff)) || (BW'(b_new) > BW'(max_bytes_ff));

   // limit register writes
   always_comb begin
      max_groups_in = max_groups_ff;
      max_bytes_in = max_bytes_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_GROUPS: max_groups_in = csr_data[MAX_GROUPS_BITS-1:0];
            CSR_MAX_BYTES:  max_bytes_in = csr_data;
            default: ;
         endcase
      end
   end

   // result and next message state
   always_comb begin
      res = grp;
      group_total_in = group_total_ff;
      byte_total_in = byte_total_ff;
      sticky_in = sticky_ff;
      if (sticky_ff != ST_OK) begin
         res.status = sticky_ff;
      end else if (grp.status == ST_OK) begin
         group_total_in = g_new;
         byte_total_in = b_new;
         if (over) begin
            res.status = ST_TOOLONG;
         end
      end
      if (res.status != ST_OK) begin
         res.byte0 = '0;
         res.byte1 = '0;
         res.byte2 = '0;
         res.byte_len = '0;
         sticky_in = res.status;
      end
      if (last_group) begin
         group_total_in = '0;
         byte_total_in = '0;
         sticky_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_groups_ff <= MAX_GROUPS_RESET;
         max_bytes_ff <= MAX_BYTES_RESET;
         group_total_ff <= '0;
         byte_total_ff <= '0;
         sticky_ff <= ST_OK;
      end else begin
         max_groups_ff <= max_groups_in;
         max_bytes_ff <= max_bytes_in;
         if (step) begin
            group_total_ff <= group_total_in;
            byte_total_ff <= byte_total_in;
            sticky_ff <= sticky_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/strict_base64_group_decoder_top.sv -----
`default_nettype none

// Channel   Direction  Payload
// req_*     in         tdata: four base64 characters, tlast: final group of message
// rsp_*     out        tdata: decoded bytes and count, tuser: status, tlast: final group
// csr_*     in         limit register writes, index 0 max groups, 1 max decoded bytes
//
// One word per clock sustained while rsp_tready is high. An accepted word sits in the
// input register, then decode and totals update into the output register (rsp_tvalid).
// Synchronous active-high reset clears totals, sticky error and valid flags and
// restores the limit registers. A stall on rsp_tready holds the output word; the
// input register still takes one more word while the output waits.
module strict_base64_group_decoder_top
   import b64d_pkg::*;
#(
   parameter int GROUP_COUNT_BITS = 20,
   parameter int BYTE_COUNT_BITS = 22
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // char0 [7:0], char1 [15:8], char2 [23:16], char3 [31:24]
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte_len [25:24], zeros above
   output logic [31:0]      rsp_tdata,
   // status [2:0]
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [MAX_BYTES_BITS-1:0] csr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_data_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   grp_result_type out_res_ff;
   logic        out_last_ff;
   logic        advance;
   grp_result_type grp, res;

   // stage handshakes
   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   b64d_group_check u_check (
      .char0      (in_data_ff[7:0]),
      .char1      (in_data_ff[15:8]),
      .char2      (in_data_ff[23:16]),
      .char3      (in_data_ff[31:24]),
      .last_group (in_last_ff),
      .grp        (grp)
   );

   b64d_msg_track #(
      .GROUP_COUNT_BITS (GROUP_COUNT_BITS),
      .BYTE_COUNT_BITS  (BYTE_COUNT_BITS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .step       (advance),
      .last_group (in_last_ff),
      .grp        (grp),
      .res        (res)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_res_ff <= res;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, out_res_ff.byte_len, out_res_ff.byte2,
                       out_res_ff.byte1, out_res_ff.byte0};
   assign rsp_tuser = out_res_ff.status;
   assign rsp_tlast = out_last_ff;

endmodule

`default_nettype wire
